@@ hdl/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types and constants for the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  localparam int unsigned NUM_W   = 31;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned STAT_W  = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [STAT_W-1:0] STATUS_OK        = STAT_W'(0);
  localparam logic [STAT_W-1:0] STATUS_BAD_RADIX = STAT_W'(1);
  localparam logic [STAT_W-1:0] STATUS_DROPPED   = STAT_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_POP_RD,
    ST_POP_OUT,
    ST_ERR
  } rdc_state_e;

  // digit stack command
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } rdc_stack_cmd_t;

endpackage

`default_nettype wire

@@ hdl/rdc_if.sv @@
// ----------------------------------------------------------------------------
// rdc_in_if / rdc_out_if
// Valid/ready channels of the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdc_in_if import rdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NUM_W-1:0]   number;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output number, output radix, input ready);
  modport sink   (input valid, input number, input radix, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DIGIT_W-1:0] digit;
  logic               last_digit;
  logic [STAT_W-1:0]  status;

  modport source (output valid, output digit, output last_digit, output status, input ready);
  modport sink   (input valid, input digit, input last_digit, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/radix_digit_converter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a 31-bit unsigned number to its digits in base 2 to 16.
// ----------------------------------------------------------------------------
// One input transfer starts a conversion; the block then drops ready until
// the last digit has been taken. The number is divided by the radix again and
// again in one shared bit-serial divider (one quotient bit per cycle); each
// remainder is pushed onto a digit stack. The
// stack is then popped and digits leave most significant first, one output
// transfer per digit, last_digit set on the least significant one. Zero gives
// the single digit 0. A radix outside 2..16 gives one result: digit 0,
// last_digit 1, status 1. A digit that finds the stack full is dropped and
// the first emitted digit carries status 2 (cannot happen for STACK_DEPTH of
// 31 or more). Per digit, the divider loop runs its load, its iterations and
// done, and emitting takes a stack read and then an output step. The divider
// is the bottleneck.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter import rdc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rdc_in_if.sink     in_ch,
  rdc_out_if.source  out_ch
);

  localparam int unsigned TW = $clog2(STACK_DEPTH + 1);  // stack pointer
  localparam int unsigned AW = $clog2(STACK_DEPTH);      // stack address

  rdc_state_e         state_q, state_d;
  logic [TW-1:0]      top_q, top_d;
  logic [NUM_W-1:0]   quot_q, quot_d;
  logic [RADIX_W-1:0] radix_q, radix_d;
  logic               dropped_q, dropped_d;
  logic               first_q, first_d;

  logic               in_fire;
  logic               out_fire;
  logic               radix_bad;
  logic               stack_full;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [NUM_W-1:0]   div_quot;
  logic [DIGIT_W-1:0] div_rem;
  rdc_stack_cmd_t     stk_cmd;
  logic [TW-1:0]      top_dec;
  logic [DIGIT_W-1:0] stk_rd_data;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_fire   = out_ch.valid && out_ch.ready;
  assign radix_bad  = (in_ch.radix < RADIX_MIN) || (in_ch.radix > RADIX_MAX);
  assign stack_full = (top_q >= TW'(STACK_DEPTH));
  assign top_dec    = top_q - TW'(1);

  // -- sequencer -------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    quot_d      = quot_q;
    radix_d     = radix_q;
    dropped_d   = dropped_q;
    first_d     = first_q;
    div_start   = 1'b0;
    stk_cmd     = '0;
    in_ch.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        // ready is high throughout idle, so valid alone marks the transfer
        if (in_ch.valid) begin
          top_d     = '0;
          dropped_d = 1'b0;
          radix_d   = in_ch.radix;
          if (radix_bad) begin
            quot_d  = '0;
            state_d = ST_ERR;
          end else begin
            quot_d  = in_ch.number;
            state_d = ST_DIV_START;
          end
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          // push remainder, or note the drop when full
          if (stack_full) begin
            dropped_d = 1'b1;
          end else begin
            stk_cmd.wr_en = 1'b1;
            top_d         = top_q + TW'(1);
          end
          quot_d = div_quot;
          if (div_quot == '0) begin
            first_d = 1'b1;
            state_d = ST_POP_RD;
          end else begin
            state_d = ST_DIV_START;
          end
        end
      end
      ST_POP_RD: begin
        stk_cmd.rd_en = 1'b1;
        top_d         = top_dec;
        state_d       = ST_POP_OUT;
      end
      ST_POP_OUT: begin
        if (out_fire) begin
          first_d = 1'b0;
          state_d = (top_q == '0) ? ST_IDLE : ST_POP_RD;
        end
      end
      ST_ERR: begin
        if (out_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      top_q     <= '0;
      quot_q    <= '0;
      dropped_q <= 1'b0;
      first_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      top_q     <= top_d;
      quot_q    <= quot_d;
      dropped_q <= dropped_d;
      first_q   <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
  end

  // -- shared divider --------------------------------------------------------
  rdc_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (quot_q),
    .divisor_i   (radix_q),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // -- digit stack -----------------------------------------------------------
  rdc_stack #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk_i     (clk_i),
    .cmd_i     (stk_cmd),
    .wr_addr_i (top_q[AW-1:0]),
    .wr_data_i (div_rem),
    .rd_addr_i (top_dec[AW-1:0]),
    .rd_data_o (stk_rd_data)
  );

  // -- result channel: stack read register holds the digit -------------------
  always_comb begin
    out_ch.valid      = (state_q == ST_POP_OUT) || (state_q == ST_ERR);
    out_ch.digit      = '0;
    out_ch.last_digit = 1'b1;
    out_ch.status     = STATUS_BAD_RADIX;
    if (state_q != ST_ERR) begin
      out_ch.digit      = stk_rd_data;
      out_ch.last_digit = (top_q == '0);
      out_ch.status     = (first_q && dropped_q) ? STATUS_DROPPED : STATUS_OK;
    end
  end

  // -- checks ----------------------------------------------------------------
  a_no_out_while_dividing : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> !div_busy
  ) else $error("result offered while divider busy");

  a_top_in_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    top_q <= TW'(STACK_DEPTH)
  ) else $error("stack pointer beyond depth");

  a_bad_radix_result : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_fire && radix_bad) |=> (out_ch.valid && out_ch.status == STATUS_BAD_RADIX)
  ) else $error("invalid radix not reported");

endmodule

`default_nettype wire

@@ hdl/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// rdc_divider
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_divider import rdc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [NUM_W-1:0]   dividend_i,
  input  wire logic [RADIX_W-1:0] divisor_i,
  output      logic               busy_o,
  output      logic               done_o,
  output      logic [NUM_W-1:0]   quotient_o,
  output      logic [DIGIT_W-1:0] remainder_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [NUM_W-1:0]   dvd_q, dvd_d;
  logic [DIGIT_W-1:0] rem_q, rem_d;
  logic [RADIX_W-1:0] dsr_q, dsr_d;
  logic [RADIX_W-1:0] trial;
  logic [RADIX_W-1:0] diff;
  logic               ge;

  // trial remainder never exceeds 2*15+1, fits RADIX_W bits
  assign trial = {rem_q, dvd_q[NUM_W-1]};
  assign ge    = (trial >= dsr_q);
  assign diff  = trial - dsr_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      dvd_d = {dvd_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

@@ hdl/rdc_stack.sv @@
// ----------------------------------------------------------------------------
// rdc_stack
// Digit stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_stack import rdc_pkg::*; #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic               clk_i,
  input  wire rdc_stack_cmd_t     cmd_i,
  input  wire logic [AW-1:0]      wr_addr_i,
  input  wire logic [DIGIT_W-1:0] wr_data_i,
  input  wire logic [AW-1:0]      rd_addr_i,
  output      logic [DIGIT_W-1:0] rd_data_o
);

  logic [DIGIT_W-1:0] mem [DEPTH];
  logic [DIGIT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire
